// File: rtl/pge_pkg.sv
package pge_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int LANES      = 4;
  localparam int MAX_KERNEL = 8;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int KW    = $clog2(MAX_KERNEL);
  localparam int VW    = 16;
  localparam int GW    = 24;
  localparam int ACC_MAX = 8388607;
  localparam int ACC_MIN = -8388608;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_MAX  = 2'd1,
    CMD_AVG  = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  localparam logic [3:0] REG_IN_WIDTH  = 4'd0;
  localparam logic [3:0] REG_IN_HEIGHT = 4'd1;
  localparam logic [3:0] REG_KERNEL_W  = 4'd2;
  localparam logic [3:0] REG_KERNEL_H  = 4'd3;
  localparam logic [3:0] REG_STRIDE_W  = 4'd4;
  localparam logic [3:0] REG_STRIDE_H  = 4'd5;
  localparam logic [3:0] REG_PAD_W     = 4'd6;
  localparam logic [3:0] REG_PAD_H     = 4'd7;

  // Control from the sequencer to every lane for one window access.
  typedef struct packed {
    logic          rd;       // read the element at addr
    logic          wr_load;  // store forward value, clear gradient
    logic          acc;      // accumulate the addressed element
    logic          is_max;   // max rule: first element >= pooled max
    logic          first;    // first window element of this item
    logic [AW-1:0] addr;
  } lane_ctl_t;

  function automatic logic signed [GW-1:0] sat_add(input logic signed [GW-1:0] a,
                                                   input logic signed [GW-1:0] b);
    logic signed [GW:0] s;
    s = {a[GW-1], a} + {b[GW-1], b};
    if (s > (GW+1)'(ACC_MAX)) return GW'(ACC_MAX);
    if (s < (GW+1)'(ACC_MIN)) return GW'(ACC_MIN);
    return s[GW-1:0];
  endfunction

endpackage

// File: rtl/pge_if.sv
interface pge_in_if;
  import pge_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [5:0] pos_x;
  logic [5:0] pos_y;
  logic signed [15:0] val0, val1, val2, val3;
  logic signed [15:0] diff0, diff1, diff2, diff3;
  modport source(output valid, cmd, pos_x, pos_y, val0, val1, val2, val3,
                 diff0, diff1, diff2, diff3, input ready);
  modport sink(input valid, cmd, pos_x, pos_y, val0, val1, val2, val3,
               diff0, diff1, diff2, diff3, output ready);
endinterface

interface pge_out_if;
  logic valid;
  logic ready;
  logic signed [23:0] grad0, grad1, grad2, grad3;
  modport source(output valid, grad0, grad1, grad2, grad3, input ready);
  modport sink(input valid, grad0, grad1, grad2, grad3, output ready);
endinterface

// File: rtl/pooling_gradient_engine_core.sv
// Backward max/avg pooling over a 64x64 plane of four Q8.8 lanes held in on-chip
// memories (4096 entries per lane). A load item passes through S_END and a read
// item through S_RD and S_END; a max item spends S_WIN and S_WB on each window
// element, then S_END; an avg item first waits in S_DIV for the bit-serial
// divider that forms diff/(kernel_w*kernel_h), then walks the window the same way.
// Each window element is a read then a write-back of the same lane memories.
// Stores are undefined until loaded; a read result is held in an output register
// until taken, and only a further read waits for it. Configure only while idle.
module pooling_gradient_engine_core import pge_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  pge_in_if.sink       in_ch,
  pge_out_if.source    out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_WIN  = 6'b000100,
    S_WB   = 6'b001000,
    S_RD   = 6'b010000,
    S_END  = 6'b100000
  } state_t;

  logic [6:0] in_width_r, in_height_r;
  logic [3:0] kernel_w_r, kernel_h_r, stride_w_r, stride_h_r;
  logic [2:0] pad_w_r, pad_h_r;
  logic [3:0] reg_idx;
  assign reg_idx    = cfg_paddr[4:2] == 3'd0 ? REG_IN_WIDTH : {1'b0, cfg_paddr[4:2]};
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r <= 7'd64; in_height_r <= 7'd64;
      kernel_w_r <= 4'd2;  kernel_h_r  <= 4'd2;
      stride_w_r <= 4'd2;  stride_h_r  <= 4'd2;
      pad_w_r    <= 3'd0;  pad_h_r     <= 3'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (reg_idx)
        REG_IN_WIDTH:  in_width_r  <= cfg_pwdata[6:0];
        REG_IN_HEIGHT: in_height_r <= cfg_pwdata[6:0];
        REG_KERNEL_W:  kernel_w_r  <= cfg_pwdata[3:0];
        REG_KERNEL_H:  kernel_h_r  <= cfg_pwdata[3:0];
        REG_STRIDE_W:  stride_w_r  <= cfg_pwdata[3:0];
        REG_STRIDE_H:  stride_h_r  <= cfg_pwdata[3:0];
        REG_PAD_W:     pad_w_r     <= cfg_pwdata[2:0];
        REG_PAD_H:     pad_h_r     <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IN_WIDTH:  cfg_prdata = {25'd0, in_width_r};
      REG_IN_HEIGHT: cfg_prdata = {25'd0, in_height_r};
      REG_KERNEL_W:  cfg_prdata = {28'd0, kernel_w_r};
      REG_KERNEL_H:  cfg_prdata = {28'd0, kernel_h_r};
      REG_STRIDE_W:  cfg_prdata = {28'd0, stride_w_r};
      REG_STRIDE_H:  cfg_prdata = {28'd0, stride_h_r};
      REG_PAD_W:     cfg_prdata = {29'd0, pad_w_r};
      REG_PAD_H:     cfg_prdata = {29'd0, pad_h_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // Clamped geometry.
  logic [7:0] iw, ih;
  logic [4:0] kw, kh;
  assign iw = in_width_r == 0 ? 8'd1 : (in_width_r > 7'(MAX_WIDTH) ? 8'(MAX_WIDTH)
                                                                 : {1'b0, in_width_r});
  assign ih = in_height_r == 0 ? 8'd1 : (in_height_r > 7'(MAX_HEIGHT) ? 8'(MAX_HEIGHT)
                                                                   : {1'b0, in_height_r});
  assign kw = kernel_w_r == 0 ? 5'd1 : (kernel_w_r > 4'(MAX_KERNEL) ? 5'(MAX_KERNEL)
                                                                   : {1'b0, kernel_w_r});
  assign kh = kernel_h_r == 0 ? 5'd1 : (kernel_h_r > 4'(MAX_KERNEL) ? 5'(MAX_KERNEL)
                                                                   : {1'b0, kernel_h_r});

  state_t state_r, state_nxt;
  logic [1:0]  cmd_r;
  logic [5:0]  px_r, py_r;
  logic signed [VW-1:0] val_r [LANES];
  logic signed [VW-1:0] diff_r [LANES];
  logic [KW:0] kx_r, ky_r, kx_nxt, ky_nxt;
  logic        first_r, first_nxt;
  logic        inside_r;
  logic signed [GW-1:0] grad_r [LANES];
  logic        out_valid_r;

  // Words are taken only in S_IDLE; a new read also waits while an earlier read word is still held and not taken.
  logic accept;
  assign in_ch.ready = (state_r == S_IDLE) &&
                       (cmd_t'(in_ch.cmd) != CMD_READ || !out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // Window coordinate of the current element.
  logic signed [11:0] sx, sy;
  logic win_in;
  assign sx = 12'(signed'({1'b0, px_r}) * signed'({1'b0, stride_w_r}))
              + 12'(kx_r) - 12'(pad_w_r);
  assign sy = 12'(signed'({1'b0, py_r}) * signed'({1'b0, stride_h_r}))
              + 12'(ky_r) - 12'(pad_h_r);
  assign win_in = !sx[11] && !sy[11] && sx < 12'(iw) && sy < 12'(ih);

  logic last_elem;
  assign last_elem = (kx_r == (KW+1)'(kw - 1)) && (ky_r == (KW+1)'(kh - 1));

  logic div_busy, div_start;
  logic div_busy_l [LANES];
  logic signed [VW-1:0] quot [LANES];
  logic [9:0] area;
  assign area      = 10'(kw * kh);
  assign div_start = accept && cmd_t'(in_ch.cmd) == CMD_AVG;

  lane_ctl_t ctl;
  always_comb begin
    ctl         = '0;
    ctl.first   = first_r;
    ctl.is_max  = cmd_r == CMD_MAX;
    ctl.addr    = {sy[YW-1:0], sx[XW-1:0]};
    state_nxt   = state_r;
    kx_nxt      = kx_r;
    ky_nxt      = ky_r;
    first_nxt   = first_r;
    unique case (state_r)
      S_IDLE: begin
        ctl.addr = {in_ch.pos_y, in_ch.pos_x};
        if (accept) begin
          unique case (cmd_t'(in_ch.cmd))
            CMD_LOAD: begin
              ctl.wr_load = (in_ch.pos_x < iw[6:0]) && (in_ch.pos_y < ih[6:0]);
              state_nxt   = S_END;
            end
            CMD_READ: begin
              ctl.rd    = 1'b1;
              state_nxt = S_RD;
            end
            CMD_MAX:  state_nxt = S_WIN;
            CMD_AVG:  state_nxt = S_DIV;
            default:  state_nxt = S_END;
          endcase
          kx_nxt    = '0;
          ky_nxt    = '0;
          first_nxt = 1'b1;
        end
      end
      S_DIV: if (!div_busy && !div_start) state_nxt = S_WIN;
      S_WIN: begin
        ctl.rd    = win_in;
        ctl.acc   = win_in;
        state_nxt = S_WB;
      end
      S_WB: begin
        ctl.first = 1'b0;
        first_nxt = 1'b0;
        if (last_elem) state_nxt = S_END;
        else begin
          state_nxt = S_WIN;
          if (kx_r == (KW+1)'(kw - 1)) begin
            kx_nxt = '0;
            ky_nxt = ky_r + 1'b1;
          end else kx_nxt = kx_r + 1'b1;
        end
      end
      S_RD:  state_nxt = S_END;
      S_END: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Pending bits are re-armed on the first element of an item (checked at S_WIN).
  lane_ctl_t lctl;
  always_comb begin
    lctl       = ctl;
    lctl.first = (state_r == S_WIN) && first_r;
  end

  logic signed [VW-1:0] in_val [LANES];
  logic signed [VW-1:0] in_dif [LANES];
  assign in_val[0] = in_ch.val0;  assign in_val[1] = in_ch.val1;
  assign in_val[2] = in_ch.val2;  assign in_val[3] = in_ch.val3;
  assign in_dif[0] = in_ch.diff0; assign in_dif[1] = in_ch.diff1;
  assign in_dif[2] = in_ch.diff2; assign in_dif[3] = in_ch.diff3;

  logic signed [GW-1:0] lane_grad [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [VW-1:0] lane_val, lane_dif;
    assign lane_val = (state_r == S_IDLE) ? in_val[l] : val_r[l];
    assign lane_dif = (cmd_r == CMD_AVG) ? quot[l] : diff_r[l];

    pge_div u_div (
      .clk, .rst_n,
      .start    (div_start),
      .dividend (in_dif[l]),
      .divisor  ((2*KW+1)'(area)),
      .busy     (div_busy_l[l]),
      .quotient (quot[l])
    );

    pge_lane u_lane (
      .clk, .rst_n,
      .ctl  (lctl),
      .val  (lane_val),
      .diff (lane_dif),
      .grad (lane_grad[l])
    );
  end

  // All dividers run in lockstep and finish together.
  always_comb begin
    div_busy = 1'b0;
    for (int l = 0; l < LANES; l++) div_busy = div_busy | div_busy_l[l];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_ch.cmd;
      px_r      <= in_ch.pos_x;
      py_r      <= in_ch.pos_y;
      inside_r  <= (in_ch.pos_x < iw[6:0]) && (in_ch.pos_y < ih[6:0]);
      for (int l = 0; l < LANES; l++) begin
        val_r[l]  <= in_val[l];
        diff_r[l] <= in_dif[l];
      end
    end
    kx_r    <= kx_nxt;
    ky_r    <= ky_nxt;
    first_r <= first_nxt;
    if (state_r == S_RD) begin
      for (int l = 0; l < LANES; l++) grad_r[l] <= inside_r ? lane_grad[l] : '0;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_RD) out_valid_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.grad0 = grad_r[0];
  assign out_ch.grad1 = grad_r[1];
  assign out_ch.grad2 = grad_r[2];
  assign out_ch.grad3 = grad_r[3];
endmodule

// File: rtl/pge_div.sv
// Restoring divider: |diff| / area, one quotient bit per cycle, sign fixed at the end.
module pge_div import pge_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [VW-1:0]  dividend,
  input  logic [2*KW:0]         divisor,
  output logic                  busy,
  output logic signed [VW-1:0]  quotient
);
  localparam int DW = 2*KW + 1;
  localparam int CW = $clog2(VW + 1);

  logic [VW-1:0] q_r, q_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, q_r[VW-1]};
    if (start) begin
      q_nxt   = dividend[VW-1] ? VW'(-dividend) : dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      neg_nxt = dividend[VW-1];
      cnt_nxt = CW'(VW);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DW'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[VW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        q_nxt   = {q_r[VW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = neg_r ? VW'(-q_r) : q_r;
endmodule

// File: rtl/pge_lane.sv
// One channel lane: its slice of the forward and gradient stores and the
// read-modify-write path. The read data is registered and written back in the next cycle.
module pge_lane import pge_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lane_ctl_t            ctl,
  input  logic signed [VW-1:0] val,
  input  logic signed [VW-1:0] diff,
  output logic signed [GW-1:0] grad
);
  logic signed [VW-1:0] fwd_mem [DEPTH];
  logic signed [GW-1:0] grd_mem [DEPTH];

  logic signed [VW-1:0] fwd_q_r;
  logic signed [GW-1:0] grd_q_r;
  logic                 acc_r, max_r;
  logic [AW-1:0]        addr_r;
  logic                 pend_r, pend_nxt;
  logic                 do_wr;

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      fwd_q_r <= fwd_mem[ctl.addr];
      grd_q_r <= grd_mem[ctl.addr];
    end
    if (ctl.wr_load) begin
      fwd_mem[ctl.addr] <= val;
      grd_mem[ctl.addr] <= '0;
    end else if (do_wr) begin
      grd_mem[addr_r] <= sat_add(grd_q_r, GW'(diff));
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= ctl.addr;
    if (!rst_n) begin
      acc_r  <= 1'b0;
      max_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      acc_r  <= ctl.acc;
      max_r  <= ctl.is_max;
      pend_r <= pend_nxt;
    end
  end

  // Pending is re-armed by the first element of each item.
  always_comb begin
    do_wr    = acc_r && (!max_r || (pend_r && fwd_q_r >= val));
    pend_nxt = pend_r;
    if (acc_r && max_r && pend_r && fwd_q_r >= val) pend_nxt = 1'b0;
    if (ctl.first) pend_nxt = 1'b1;
  end

  assign grad = grd_q_r;
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import pge_pkg::*;

  localparam int LIMIT       = 3000000;
  localparam int N_RANDOM    = 1620;
  localparam int N_PHASES    = 6;
  localparam int SETTLE      = 400;
  localparam int LOAD_SPAN   = 12;

  typedef struct packed {
    cmd_t             cmd;
    logic [5:0]       x;
    logic [5:0]       y;
    logic [3:0][15:0] v;
    logic [3:0][15:0] d;
  } word_t;

  typedef logic [3:0][23:0] grads_t;

  typedef struct packed {
    word_t  w;
    logic   typed;
    grads_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  pge_in_if  in_if();
  pge_out_if out_if();

  pooling_gradient_engine_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Shadow copy of the block's registers and element stores.
  int unsigned shadow_reg [8];
  int fwd_vals [DEPTH][LANES];
  int grad_acc [DEPTH][LANES];
  bit loaded [DEPTH];

  grads_t pending_grads[$];
  int mismatches;
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;
  row_t dir_tab [20];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker: every accepted word is compared with the oldest expectation.
  always @(posedge clk) begin
    grads_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h %h %h %h",
                                       out_if.grad0, out_if.grad1, out_if.grad2, out_if.grad3);
      end else begin
        want = pending_grads.pop_front();
        if (want[0] !== out_if.grad0 || want[1] !== out_if.grad1 ||
            want[2] !== out_if.grad2 || want[3] !== out_if.grad3) begin
          mismatches++;
          if (mismatches <= 10)
            $display("grad mismatch: expected %h %h %h %h, got %h %h %h %h",
                     want[0], want[1], want[2], want[3],
                     out_if.grad0, out_if.grad1, out_if.grad2, out_if.grad3);
        end
      end
    end
  end

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int sat24(int a, int b);
    longint s;
    s = longint'(a) + longint'(b);
    return s > ACC_MAX ? ACC_MAX : (s < ACC_MIN ? ACC_MIN : int'(s));
  endfunction

  // Applies one word to the shadow stores; returns 1 with the read-back when it yields a result.
  function automatic logic pool_backward(input word_t w, output grads_t res);
    int iw, ih, kw, kh, px, py, sx, sy, e;
    int val[LANES];
    int dif[LANES];
    bit open[LANES];
    bit in_plane;
    iw = clampi(shadow_reg[REG_IN_WIDTH], 1, MAX_WIDTH);
    ih = clampi(shadow_reg[REG_IN_HEIGHT], 1, MAX_HEIGHT);
    kw = clampi(shadow_reg[REG_KERNEL_W], 1, MAX_KERNEL);
    kh = clampi(shadow_reg[REG_KERNEL_H], 1, MAX_KERNEL);
    px = w.x;
    py = w.y;
    res = '0;
    for (int l = 0; l < LANES; l++) begin
      val[l] = $signed(w.v[l]);
      dif[l] = $signed(w.d[l]);
      open[l] = 1'b1;
    end
    in_plane = px < iw && py < ih;
    e = py * MAX_WIDTH + px;
    if (w.cmd == CMD_LOAD) begin
      if (in_plane) begin
        loaded[e] = 1'b1;
        for (int l = 0; l < LANES; l++) begin
          fwd_vals[e][l] = val[l];
          grad_acc[e][l] = 0;
        end
      end
      return 1'b0;
    end
    if (w.cmd == CMD_READ) begin
      for (int l = 0; l < LANES; l++) res[l] = in_plane ? grad_acc[e][l][23:0] : 24'd0;
      return 1'b1;
    end
    if (w.cmd == CMD_AVG) begin
      for (int l = 0; l < LANES; l++) dif[l] = dif[l] / (kw * kh);
    end
    for (int ky = 0; ky < kh; ky++) begin
      sy = py * int'(shadow_reg[REG_STRIDE_H]) + ky - int'(shadow_reg[REG_PAD_H]);
      if (sy < 0 || sy >= ih) continue;
      for (int kx = 0; kx < kw; kx++) begin
        sx = px * int'(shadow_reg[REG_STRIDE_W]) + kx - int'(shadow_reg[REG_PAD_W]);
        if (sx < 0 || sx >= iw) continue;
        e = sy * MAX_WIDTH + sx;
        for (int l = 0; l < LANES; l++) begin
          if (w.cmd == CMD_AVG) begin
            grad_acc[e][l] = sat24(grad_acc[e][l], dif[l]);
          end else if (open[l] && fwd_vals[e][l] >= val[l]) begin
            open[l] = 1'b0;
            grad_acc[e][l] = sat24(grad_acc[e][l], dif[l]);
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // True when the word touches only elements that have been loaded.
  function automatic bit word_ok(input word_t w);
    int iw, ih, kw, kh, px, py, sx, sy;
    iw = clampi(shadow_reg[REG_IN_WIDTH], 1, MAX_WIDTH);
    ih = clampi(shadow_reg[REG_IN_HEIGHT], 1, MAX_HEIGHT);
    kw = clampi(shadow_reg[REG_KERNEL_W], 1, MAX_KERNEL);
    kh = clampi(shadow_reg[REG_KERNEL_H], 1, MAX_KERNEL);
    px = w.x;
    py = w.y;
    if (w.cmd == CMD_LOAD) return 1'b1;
    if (w.cmd == CMD_READ) return !(px < iw && py < ih) || loaded[py * MAX_WIDTH + px];
    for (int ky = 0; ky < kh; ky++) begin
      sy = py * int'(shadow_reg[REG_STRIDE_H]) + ky - int'(shadow_reg[REG_PAD_H]);
      if (sy < 0 || sy >= ih) continue;
      for (int kx = 0; kx < kw; kx++) begin
        sx = px * int'(shadow_reg[REG_STRIDE_W]) + kx - int'(shadow_reg[REG_PAD_W]);
        if (sx < 0 || sx >= iw) continue;
        if (!loaded[sy * MAX_WIDTH + sx]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [15:0] rand_q88(int extreme_pct);
    logic [15:0] picks [4];
    picks = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    if ($urandom_range(99) < extreme_pct) return picks[$urandom_range(3)];
    return 16'($urandom);
  endfunction

  // Drives one word until taken, then may idle at random; the caller is at a rising edge.
  task automatic send_word(input word_t w, input logic typed, input grads_t want);
    grads_t res;
    in_if.valid <= 1'b1;
    in_if.cmd   <= w.cmd;
    in_if.pos_x <= w.x;
    in_if.pos_y <= w.y;
    in_if.val0  <= w.v[0];
    in_if.val1  <= w.v[1];
    in_if.val2  <= w.v[2];
    in_if.val3  <= w.v[3];
    in_if.diff0 <= w.d[0];
    in_if.diff1 <= w.d[1];
    in_if.diff2 <= w.d[2];
    in_if.diff3 <= w.d[3];
    do @(posedge clk); while (!in_if.ready);
    if (pool_backward(w, res)) pending_grads.push_back(typed ? want : res);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [3:0] idx, input int unsigned value);
    in_if.valid <= 1'b0;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_IN_WIDTH, REG_IN_HEIGHT: shadow_reg[idx] = value & 32'h7f;
      REG_PAD_W, REG_PAD_H:        shadow_reg[idx] = value & 32'h7;
      default:                     shadow_reg[idx] = value & 32'hf;
    endcase
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic row_t mk_row(cmd_t c, int x, int y, int v0, int v1, int v2, int v3,
                                  int d0, int d1, int d2, int d3, logic typed,
                                  int g0, int g1, int g2, int g3);
    row_t r;
    r.w.cmd = c;
    r.w.x = 6'(x);
    r.w.y = 6'(y);
    r.w.v = {16'(v3), 16'(v2), 16'(v1), 16'(v0)};
    r.w.d = {16'(d3), 16'(d2), 16'(d1), 16'(d0)};
    r.typed = typed;
    r.want = {24'(g3), 24'(g2), 24'(g1), 24'(g0)};
    return r;
  endfunction

  function automatic word_t random_word();
    word_t w;
    int iw, ih, kw, kh, bw, bh, r, sx, sy;
    iw = clampi(shadow_reg[REG_IN_WIDTH], 1, MAX_WIDTH);
    ih = clampi(shadow_reg[REG_IN_HEIGHT], 1, MAX_HEIGHT);
    kw = clampi(shadow_reg[REG_KERNEL_W], 1, MAX_KERNEL);
    kh = clampi(shadow_reg[REG_KERNEL_H], 1, MAX_KERNEL);
    bw = clampi(iw, 1, LOAD_SPAN);
    bh = clampi(ih, 1, LOAD_SPAN);
    r = $urandom_range(99);
    w.cmd = r < 12 ? CMD_LOAD : (r < 42 ? CMD_MAX : (r < 67 ? CMD_AVG : CMD_READ));
    for (int l = 0; l < LANES; l++) begin
      w.v[l] = rand_q88(10);
      w.d[l] = rand_q88(25);
    end
    if (w.cmd == CMD_LOAD || w.cmd == CMD_READ) begin
      if ($urandom_range(99) < 85) begin
        w.x = 6'($urandom_range(bw - 1));
        w.y = 6'($urandom_range(bh - 1));
      end else begin
        w.x = 6'($urandom);
        w.y = 6'($urandom);
      end
    end else begin
      if ($urandom_range(99) < 75) begin
        w.x = 6'($urandom_range(clampi((bw + shadow_reg[REG_PAD_W]) /
                                       clampi(shadow_reg[REG_STRIDE_W], 1, 8), 0, 63)));
        w.y = 6'($urandom_range(clampi((bh + shadow_reg[REG_PAD_H]) /
                                       clampi(shadow_reg[REG_STRIDE_H], 1, 8), 0, 63)));
      end else begin
        w.x = 6'($urandom);
        w.y = 6'($urandom);
      end
      // Aim the pooled maximum at a stored value so that ties and later hits both occur.
      if (w.cmd == CMD_MAX && $urandom_range(99) < 60) begin
        sy = w.y * int'(shadow_reg[REG_STRIDE_H]) + $urandom_range(kh - 1)
             - int'(shadow_reg[REG_PAD_H]);
        sx = w.x * int'(shadow_reg[REG_STRIDE_W]) + $urandom_range(kw - 1)
             - int'(shadow_reg[REG_PAD_W]);
        if (sy >= 0 && sy < ih && sx >= 0 && sx < iw) begin
          for (int l = 0; l < LANES; l++)
            w.v[l] = 16'(fwd_vals[sy * MAX_WIDTH + sx][l] + int'($urandom_range(2)) - 1);
        end
      end
    end
    return w;
  endfunction

  initial begin
    word_t w;
    int iw, ih, done;
    cycles = 0;
    mismatches = 0;
    send_idle_pct = 9;
    recv_idle_pct = 55;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_LOAD;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    {in_if.val0, in_if.val1, in_if.val2, in_if.val3} = '0;
    {in_if.diff0, in_if.diff1, in_if.diff2, in_if.diff3} = '0;
    out_if.ready = 1'b0;
    shadow_reg = '{64, 64, 2, 2, 2, 2, 0, 0};
    foreach (fwd_vals[i, l]) begin
      fwd_vals[i][l] = 0;
      grad_acc[i][l] = 0;
    end
    foreach (loaded[i]) loaded[i] = 1'b0;

    dir_tab[0]  = mk_row(CMD_LOAD, 0, 0, 32767, -32768, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[1]  = mk_row(CMD_LOAD, 1, 0, -32768, 32767, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[2]  = mk_row(CMD_LOAD, 0, 1, 5, 5, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[3]  = mk_row(CMD_LOAD, 1, 1, 300, -300, 1, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[4]  = mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    dir_tab[5]  = mk_row(CMD_MAX, 0, 0, 32767, -32768, -1, 1, 32767, -32768, 256, -1,
                         0, 0, 0, 0, 0);
    dir_tab[6]  = mk_row(CMD_AVG, 0, 0, 0, 0, 0, 0, 32767, -32768, -3, 3, 0, 0, 0, 0, 0);
    dir_tab[7]  = mk_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[8]  = mk_row(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[9]  = mk_row(CMD_READ, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[10] = mk_row(CMD_READ, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[11] = mk_row(CMD_LOAD, 62, 62, -5, -5, -5, -5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[12] = mk_row(CMD_LOAD, 63, 62, 7, 7, 7, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[13] = mk_row(CMD_LOAD, 62, 63, 7, 7, 7, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[14] = mk_row(CMD_LOAD, 63, 63, 9, 9, 9, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[15] = mk_row(CMD_READ, 63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    dir_tab[16] = mk_row(CMD_MAX, 31, 31, 7, 8, 9, 10, 100, 200, 300, 400, 0, 0, 0, 0, 0);
    dir_tab[17] = mk_row(CMD_AVG, 31, 31, 0, 0, 0, 0, -32768, 32767, 4, -4, 0, 0, 0, 0, 0);
    dir_tab[18] = mk_row(CMD_READ, 63, 62, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    dir_tab[19] = mk_row(CMD_READ, 63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);

    done = 0;
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      if (p == 1) begin
        for (int i = 0; i < 8; i++)
          write_reg(4'(i), (i < 2) ? 127 : ((i < 6) ? 15 : 7));
      end else if (p == 2) begin
        for (int i = 0; i < 8; i++) write_reg(4'(i), 0);
      end else if (p > 2) begin
        write_reg(REG_IN_WIDTH, $urandom_range(1, 12));
        write_reg(REG_IN_HEIGHT, $urandom_range(1, 12));
        write_reg(REG_KERNEL_W, $urandom_range(0, 15));
        write_reg(REG_KERNEL_H, $urandom_range(0, 15));
        write_reg(REG_STRIDE_W, $urandom_range(0, 15));
        write_reg(REG_STRIDE_H, $urandom_range(0, 15));
        write_reg(REG_PAD_W, $urandom_range(0, 7));
        write_reg(REG_PAD_H, $urandom_range(0, 7));
      end
      @(posedge clk);
      // A corner block of the plane is loaded first; random words that would touch
      // an unwritten element are drawn again.
      iw = clampi(shadow_reg[REG_IN_WIDTH], 1, MAX_WIDTH);
      ih = clampi(shadow_reg[REG_IN_HEIGHT], 1, MAX_HEIGHT);
      for (int y = 0; y < clampi(ih, 1, LOAD_SPAN); y++) begin
        for (int x = 0; x < clampi(iw, 1, LOAD_SPAN); x++) begin
          w.cmd = CMD_LOAD;
          w.x = 6'(x);
          w.y = 6'(y);
          for (int l = 0; l < LANES; l++) begin
            w.v[l] = rand_q88(10);
            w.d[l] = 16'($urandom);
          end
          send_word(w, 1'b0, '0);
        end
      end
      for (int i = 0; i < N_RANDOM / N_PHASES; i++) begin
        if (done * 3 < N_RANDOM) begin
          send_idle_pct = 9;
          recv_idle_pct = 55;
        end else if (done * 3 < 2 * N_RANDOM) begin
          send_idle_pct = 55;
          recv_idle_pct = 9;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        do w = random_word(); while (!word_ok(w));
        send_word(w, 1'b0, '0);
        done++;
      end
    end

    drain();
    if (mismatches == 0 && pending_grads.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
